[hdl/vas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_pkg: shared types and constants of the voice activity segmenter
// Widths, reset values of the settings registers, register indexes, marker
// tags, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package vas_pkg;

	// Largest number of frames in one chunk; a frame that reaches it ends the chunk.
	localparam int MAX_CHUNK_FRAMES = 16384;

	localparam int SAMPLE_W = 16;
	localparam int ABS_W    = SAMPLE_W + 1;
	localparam int CHUNK_W  = $clog2(MAX_CHUNK_FRAMES + 1);
	localparam int SUM_W    = 31;
	localparam int AVG_W    = 17;
	localparam int CNT_W    = 20;
	localparam int TICK_W   = 16;
	localparam int THR_W    = 16;
	localparam int IDX_W    = 3;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	// Reset values of the settings registers.
	localparam logic [THR_W-1:0]  THRESH_RST  = THR_W'(2000);
	localparam logic [CNT_W-1:0]  FLUSH_RST   = CNT_W'(2048);
	localparam logic [CNT_W-1:0]  BREAK_RST   = CNT_W'(15000);
	localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(800);

	// Register indexes of the settings port.
	localparam logic [IDX_W-1:0] REG_THRESH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FLUSH   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_BREAK   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_TIMEOUT = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_CAPTURE = IDX_W'(4);

	// Input item kinds.
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		TAG_OPEN  = 2'd0,
		TAG_DATA  = 2'd1,
		TAG_PAUSE = 2'd2,
		TAG_END   = 2'd3
	} tag_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_DIV    = 2'd1,
		S_DECIDE = 2'd2,
		S_EMIT   = 2'd3
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic absorb;
		logic decide;
		logic pop;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic chunk_close;
		logic div_busy;
		logic pend_any;
		logic pend_last;
		logic out_free;
	} dp_status_t;

endpackage

[hdl/vas_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_div: iterative restoring divider
// Divides the chunk sum by the chunk frame count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vas_div
	import vas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   num,
	input  logic [CHUNK_W-1:0] den,
	output logic               busy,
	output logic [SUM_W-1:0]   quot
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     num_q;
	logic [CHUNK_W-1:0]   den_q;
	logic [CHUNK_W-1:0]   rem_q;
	logic [CHUNK_W:0]     rem_sh;
	logic [CHUNK_W:0]     rem_sub;
	logic                 q_bit;

	// Trial subtraction of one step.
	always_comb begin
		rem_sh  = {rem_q, num_q[SUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		q_bit   = (rem_sh >= {1'b0, den_q});
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift register for dividend and quotient, and the partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[CHUNK_W-1:0] : rem_sh[CHUNK_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule

[hdl/vas_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_ctrl: sequencing controller
// Takes input beats, waits for the divider, triggers the marker decision and
// hands the pending markers one by one to the output register.
// ----------------------------------------------------------------------------
module vas_ctrl
	import vas_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.absorb = 1'b0;
		cmd.decide = 1'b0;
		cmd.pop    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.absorb = 1'b1;
					if (status.chunk_close) begin
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (!status.div_busy) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (!status.pend_any) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.pop = 1'b1;
					if (status.pend_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/vas_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_dp: segmenter datapath
// Settings registers, chunk accumulation, session counters, the divider, the
// marker decision and the output register.
// ----------------------------------------------------------------------------
module vas_dp
	import vas_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// settings writes
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [31:0]                cfg_data,
	// input payload
	input  logic                       op,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       chunk_end,
	// output register
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [1:0]                 tag,
	output logic [CNT_W-1:0]           frame_count,
	output logic [AVG_W-1:0]           mean_level,
	output logic                       last,
	// controller link
	input  ctrl_cmd_t                  cmd,
	output dp_status_t                 status
);

	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// Settings registers.
	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  flush_lim_q;
	logic [CNT_W-1:0]  brk_lim_q;
	logic [TICK_W-1:0] tmo_q;
	logic              cap_en_q;

	// Session state.
	logic               in_utt_q;
	logic [CNT_W-1:0]   flush_cnt_q;
	logic [CNT_W-1:0]   total_cnt_q;
	logic [TICK_W-1:0]  ticks_q;
	logic [SUM_W-1:0]   chunk_sum_q;
	logic [CHUNK_W-1:0] chunk_frm_q;

	// Closed chunk and pending markers.
	logic [CHUNK_W-1:0] frames_q;
	logic [3:0]         pend_q;
	logic [CNT_W-1:0]   data_cnt_q;
	logic [AVG_W-1:0]   avg_q;

	// Output register.
	logic               out_valid_q;
	tag_t               out_tag_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic [AVG_W-1:0]   out_avg_q;
	logic               out_last_q;

	// Divider link.
	logic               div_busy;
	logic [SUM_W-1:0]   div_quot;
	logic               div_start;

	// Frame accumulation.
	logic [ABS_W-1:0]   abs_l;
	logic [ABS_W-1:0]   abs_r;
	logic [ABS_W-1:0]   abs_pair;
	logic [SUM_W-1:0]   sum_new;
	logic [CHUNK_W-1:0] frm_new;
	logic               is_frame;
	logic               close;
	logic               cfg_off;

	// Decision.
	logic [AVG_W-1:0]   avg;
	logic [CNT_W:0]     flush_sum;
	logic [CNT_W:0]     total_sum;
	logic [CNT_W-1:0]   flush_n;
	logic [CNT_W-1:0]   total_n;
	logic [CNT_W-1:0]   total1;
	logic [TICK_W-1:0]  ticks_d;
	logic               above;
	logic               utt;
	logic               f_start;
	logic               f_data;
	logic               f_brk;
	logic               f_end;
	logic               tmo;

	// Marker selection.
	logic [3:0]         pend_low;
	logic [3:0]         pend_rest;
	tag_t               pop_tag;

	function automatic logic [ABS_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] s);
		logic [ABS_W-1:0] ext;
		begin
			ext = ABS_W'(s);
			if (s[SAMPLE_W-1]) begin
				ext = {1'b1, s} ^ '1;
				ext = ext + 1'b1;
			end
			abs_sample = ext;
		end
	endfunction

	// Magnitudes of both samples, the updated chunk and the chunk end test.
	always_comb begin
		abs_l    = abs_sample(left_sample);
		abs_r    = abs_sample(right_sample);
		abs_pair = abs_l + abs_r;
		sum_new  = chunk_sum_q + SUM_W'(abs_pair);
		frm_new  = chunk_frm_q + 1'b1;
		is_frame = cap_en_q && (op == OP_FRAME);
		close    = is_frame && (chunk_end ||
			(32'(frm_new) >= 32'(MAX_CHUNK_FRAMES)));
		div_start = cmd.absorb && close;
		cfg_off   = cfg_we && (cfg_index == REG_CAPTURE) && !cfg_data[0];
	end

	vas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_new),
		.den    (frm_new),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Decision at a chunk end: start, flush, break and timeout in that order.
	always_comb begin
		avg       = div_quot[AVG_W-1:0];
		flush_sum = {1'b0, flush_cnt_q} + (CNT_W+1)'(frames_q);
		total_sum = {1'b0, total_cnt_q} + (CNT_W+1)'(frames_q);
		flush_n   = flush_sum[CNT_W] ? CNT_MAX : flush_sum[CNT_W-1:0];
		total_n   = total_sum[CNT_W] ? CNT_MAX : total_sum[CNT_W-1:0];
		above     = avg > AVG_W'(thr_q);
		f_start   = above && !in_utt_q;
		utt       = in_utt_q || above;
		ticks_d   = above ? '0 : ticks_q;
		f_data    = utt && (flush_n > flush_lim_q);
		total1    = utt ? total_n : '0;
		f_brk     = (total1 > brk_lim_q) && (avg < AVG_W'(thr_q >> 1));
		tmo       = ticks_d >= tmo_q;
		f_end     = tmo && utt;
	end

	// Settings registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESH_RST;
			flush_lim_q <= FLUSH_RST;
			brk_lim_q   <= BREAK_RST;
			tmo_q       <= TIMEOUT_RST;
			cap_en_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESH:  thr_q       <= cfg_data[THR_W-1:0];
				REG_FLUSH:   flush_lim_q <= cfg_data[CNT_W-1:0];
				REG_BREAK:   brk_lim_q   <= cfg_data[CNT_W-1:0];
				REG_TIMEOUT: tmo_q       <= cfg_data[TICK_W-1:0];
				REG_CAPTURE: cap_en_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Session state: cleared when capture is off, advanced by beats and decisions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_utt_q    <= 1'b0;
			flush_cnt_q <= '0;
			total_cnt_q <= '0;
			ticks_q     <= '0;
			chunk_sum_q <= '0;
			chunk_frm_q <= '0;
			pend_q      <= '0;
		end else if (cfg_off || (cmd.absorb && !cap_en_q)) begin
			in_utt_q    <= 1'b0;
			flush_cnt_q <= '0;
			total_cnt_q <= '0;
			ticks_q     <= '0;
			chunk_sum_q <= '0;
			chunk_frm_q <= '0;
		end else if (cmd.absorb) begin
			if (op == OP_TICK) begin
				if (ticks_q != TICK_MAX) begin
					ticks_q <= ticks_q + 1'b1;
				end
			end else if (close) begin
				chunk_sum_q <= '0;
				chunk_frm_q <= '0;
			end else begin
				chunk_sum_q <= sum_new;
				chunk_frm_q <= frm_new;
			end
		end else if (cmd.decide) begin
			pend_q <= {f_end, f_brk, f_data, f_start};
			if (tmo) begin
				in_utt_q    <= 1'b0;
				flush_cnt_q <= '0;
				total_cnt_q <= '0;
				ticks_q     <= '0;
			end else begin
				in_utt_q    <= utt;
				flush_cnt_q <= f_data ? '0 : flush_n;
				total_cnt_q <= f_brk ? '0 : total1;
				ticks_q     <= ticks_d;
			end
		end else if (cmd.pop) begin
			pend_q <= pend_rest;
		end
	end

	// Closed chunk size and marker payload.
	always_ff @(posedge clk) begin
		if (div_start) begin
			frames_q <= frm_new;
		end
		if (cmd.decide) begin
			data_cnt_q <= flush_n;
			avg_q      <= avg;
		end
	end

	// The earliest pending marker goes out first.
	always_comb begin
		pend_low  = pend_q & (~pend_q + 4'd1);
		pend_rest = pend_q & ~pend_low;
		if (pend_q[0]) begin
			pop_tag = TAG_OPEN;
		end else if (pend_q[1]) begin
			pop_tag = TAG_DATA;
		end else if (pend_q[2]) begin
			pop_tag = TAG_PAUSE;
		end else begin
			pop_tag = TAG_END;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_tag_q  <= pop_tag;
			out_cnt_q  <= (pop_tag == TAG_DATA) ? data_cnt_q : '0;
			out_avg_q  <= avg_q;
			out_last_q <= (pend_rest == 4'd0);
		end
	end

	assign out_valid   = out_valid_q;
	assign tag         = out_tag_q;
	assign frame_count = out_cnt_q;
	assign mean_level  = out_avg_q;
	assign last        = out_last_q;

	assign status.chunk_close = close;
	assign status.div_busy    = div_busy;
	assign status.pend_any    = (pend_q != 4'd0);
	assign status.pend_last   = (pend_q != 4'd0) && (pend_rest == 4'd0);
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

[hdl/voice_activity_segmenter.sv]
`timescale 1ns / 1ps
// A frame that does not end a chunk, a tick or an item taken with capture off
// leaves the block ready again in the next cycle.
// A chunk end passes through accept, 31 divider steps, a state to see the
// divider finish and the decision, then sends one marker per cycle while the
// output register is free, or returns to idle when the chunk gives no marker.
// Asynchronous reset restores the default settings, with capture off.
// ----------------------------------------------------------------------------
// voice_activity_segmenter: energy based voice activity segmenter
// Averages the absolute sample level of each chunk and emits start, data
// flush, break and end markers for the speech session.
// ----------------------------------------------------------------------------
module voice_activity_segmenter
	import vas_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// settings port
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [31:0]                cfg_data,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       chunk_end,
	// output channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 tag,
	output logic [CNT_W-1:0]           frame_count,
	output logic [AVG_W-1:0]           mean_level,
	output logic                       last
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The user must write settings only while the block is idle; the block does not enforce it.
	assign cfg_ready = 1'b1;

	vas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	vas_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.chunk_end    (chunk_end),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.tag          (tag),
		.frame_count  (frame_count),
		.mean_level   (mean_level),
		.last         (last),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

[hdl/vas_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_chk: port checker for the voice activity segmenter
// Watches the output markers and the output handshake at the top level.
// ----------------------------------------------------------------------------
module vas_chk
	import vas_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 tag,
	input logic [CNT_W-1:0]           frame_count,
	input logic [AVG_W-1:0]           mean_level,
	input logic                       last
);

	// A stalled marker keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag) &&
			$stable(frame_count) && $stable(mean_level) && $stable(last))
		else $error("output beat changed while stalled");

	// Only a data flush carries a frame count.
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tag != TAG_DATA) |-> frame_count == '0)
		else $error("frame count on a marker other than data flush");

	// The end marker is always the final marker of its chunk.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tag == TAG_END) |-> last)
		else $error("end marker not flagged as last");

	// An average never exceeds the largest stereo frame magnitude.
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mean_level[AVG_W-1] |-> mean_level[AVG_W-2:0] == '0)
		else $error("average amplitude out of range");

	// A data flush never reports an empty flush.
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tag == TAG_DATA) |-> frame_count != '0)
		else $error("data flush with zero frames");

endmodule

bind voice_activity_segmenter vas_chk u_vas_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.tag         (tag),
	.frame_count (frame_count),
	.mean_level  (mean_level),
	.last        (last)
);
